FILE: src/bad_pkg.sv
package bad_pkg;

  // CORDIC datapath width: 61-bit scaled differences plus gain headroom
  localparam int XW = 64;
  // angle accumulator, signed picodegrees
  localparam int ZW = 50;
  // quotient bits of the picodegree to Q9.16 conversion
  localparam int QW = 26;
  // numerator bits of that conversion: 16 * |p| + ROUND_C stays below 2^52
  localparam int NW = 52;
  // the top 32 numerator bits feed the reciprocal multiply
  localparam int NHI = 32;
  // result width, signed Q9.16
  localparam int OW = 26;
  // fixed pre-scale target of the differences
  localparam int SCALE_TOP = 60;
  // register stages from the last CORDIC stage to the result
  localparam int CONV_STAGES = 6;

  localparam logic signed [ZW-1:0] PICO_90  = 50'sd90000000000000;
  localparam logic signed [ZW-1:0] PICO_180 = 50'sd180000000000000;

  // picodegrees * 2^16 / 1e12 reduces to (16 * p + ROUND_C) / 5^12
  localparam logic [31:0] DIV_D   = 32'd244140625;
  localparam logic [31:0] ROUND_C = 32'd122070312;

  // floor(2^59 / 5^12); the top 32 numerator bits times this, taken from bit 39 up,
  // undershoots the quotient by at most one
  localparam logic [31:0] RECIP       = 32'd2361183241;
  localparam int          RECIP_SHIFT = 39;

  localparam logic [QW-1:0] LOW_MAG  = 5898240;
  localparam logic [QW-1:0] HIGH_MAG = 17694720;
  localparam logic signed [OW-1:0] OUT_LOW  = -5898240;
  localparam logic signed [OW-1:0] OUT_HIGH = 17694720;

  typedef struct packed {
    logic vert;    // dx is zero
    logic dy_neg;  // dy below zero
    logic flip;    // dx below zero, vector turned through 180 degrees
  } side_t;

  // atan(2^-idx) in picodegrees
  function automatic logic signed [ZW-1:0] stage_angle(input int unsigned idx);
    logic [63:0] r;
    case (idx)
      0:  r = 64'd45000000000000;
      1:  r = 64'd26565051177078;
      2:  r = 64'd14036243467926;
      3:  r = 64'd7125016348902;
      4:  r = 64'd3576334374997;
      5:  r = 64'd1789910608246;
      6:  r = 64'd895173710211;
      7:  r = 64'd447614170861;
      8:  r = 64'd223810500369;
      9:  r = 64'd111905677066;
      10: r = 64'd55952891894;
      11: r = 64'd27976452617;
      12: r = 64'd13988227142;
      13: r = 64'd6994113675;
      14: r = 64'd3497056851;
      15: r = 64'd1748528427;
      16: r = 64'd874264214;
      default: r = (64'd57295779513082 + (64'd1 << (idx - 1))) >> idx;
    endcase
    return r[ZW-1:0];
  endfunction

endpackage

FILE: src/bad_prep.sv
module bad_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   end_y_i,
  output logic                            valid_o,
  output logic signed [bad_pkg::XW-1:0]   x_o,
  output logic signed [bad_pkg::XW-1:0]   y_o,
  output bad_pkg::side_t                  side_o
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int XW    = bad_pkg::XW;
  localparam int GUARD = bad_pkg::SCALE_TOP - COORD_WIDTH;

  logic signed [DW-1:0] dx, dy, ndx, ndy, xin, yin;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  bad_pkg::side_t       side_d, side_q;
  logic                 valid_q;

  always_comb begin
    dx  = DW'(end_x_i) - DW'(start_x_i);
    dy  = DW'(end_y_i) - DW'(start_y_i);
    ndx = DW'(start_x_i) - DW'(end_x_i);
    ndy = DW'(start_y_i) - DW'(end_y_i);
    side_d.vert   = (dx == '0);
    side_d.dy_neg = dy[DW-1];
    side_d.flip   = dx[DW-1];
    // turn a left-pointing vector into the right half-plane
    xin = side_d.flip ? ndx : dx;
    yin = side_d.flip ? ndy : dy;
    x_d = XW'(xin) <<< GUARD;
    y_d = XW'(yin) <<< GUARD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign side_o  = side_q;

endmodule

FILE: src/bad_cordic_stage.sv
module bad_cordic_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [bad_pkg::XW-1:0]   x_i,
  input  logic signed [bad_pkg::XW-1:0]   y_i,
  input  logic signed [bad_pkg::ZW-1:0]   z_i,
  input  bad_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic signed [bad_pkg::XW-1:0]   x_o,
  output logic signed [bad_pkg::XW-1:0]   y_o,
  output logic signed [bad_pkg::ZW-1:0]   z_o,
  output bad_pkg::side_t                  side_o
);

  localparam int XW = bad_pkg::XW;
  localparam int ZW = bad_pkg::ZW;
  localparam logic signed [ZW-1:0] ANG = bad_pkg::stage_angle(IDX);

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  bad_pkg::side_t       side_q;
  logic                 valid_q;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // rotate towards the x axis
  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANG;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

FILE: src/bad_div.sv
module bad_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [bad_pkg::ZW-1:0]   z_i,
  input  bad_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic signed [bad_pkg::OW-1:0]   angle_o
);

  localparam int ZW  = bad_pkg::ZW;
  localparam int QW  = bad_pkg::QW;
  localparam int NW  = bad_pkg::NW;
  localparam int NHI = bad_pkg::NHI;
  localparam int OW  = bad_pkg::OW;
  localparam int PW  = ZW + 5;

  // angle in picodegrees, with the half-turn and vertical cases applied
  logic signed [ZW-1:0] pico_d, pico_q;
  logic                 pico_vld_q;

  always_comb begin
    if (side_i.vert) begin
      pico_d = side_i.dy_neg ? -bad_pkg::PICO_90 : bad_pkg::PICO_90;
    end else if (side_i.flip) begin
      pico_d = z_i + bad_pkg::PICO_180;
    end else begin
      pico_d = z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pico_vld_q <= 1'b0;
    end else begin
      pico_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pico_q <= pico_d;
  end

  // rounding numerator of the magnitude: 16 * |p| + half divisor
  logic signed [PW-1:0] p16, num;
  logic signed [PW-1:0] rnd;
  logic                 neg;

  assign p16 = PW'(pico_q) <<< 4;
  assign rnd = PW'(bad_pkg::ROUND_C);
  assign neg = pico_q[ZW-1];
  assign num = neg ? rnd - p16 : p16 + rnd;

  logic [NW-1:0] num_q;
  logic          num_neg_q;
  logic          num_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
    end else begin
      num_vld_q <= pico_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num[NW-1:0];
    num_neg_q <= neg;
  end

  // estimate the quotient from the top numerator bits
  logic [NHI-1:0] nhi;
  logic [63:0]    prod_d, prod_q;
  logic [31:0]    nlo_p_q;
  logic           prod_neg_q;
  logic           prod_vld_q;

  assign nhi    = num_q[NW-1:NW-NHI];
  assign prod_d = 64'(nhi) * 64'(bad_pkg::RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= num_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    nlo_p_q    <= num_q[31:0];
    prod_neg_q <= num_neg_q;
  end

  // multiply the estimate back; only the low bits of the product matter
  logic [QW-2:0] qest;
  logic [31:0]   qd_d, qd_q;
  logic [QW-2:0] qest_q;
  logic [31:0]   nlo_m_q;
  logic          qd_neg_q;
  logic          qd_vld_q;

  assign qest = prod_q[63:bad_pkg::RECIP_SHIFT];
  assign qd_d = 32'(qest) * bad_pkg::DIV_D;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qd_vld_q <= 1'b0;
    end else begin
      qd_vld_q <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q     <= qd_d;
    qest_q   <= qest;
    nlo_m_q  <= nlo_p_q;
    qd_neg_q <= prod_neg_q;
  end

  // the remainder is below twice the divisor: bump the estimate once if needed
  logic [31:0]   rem;
  logic          ge;
  logic [QW-1:0] q_d, q_q;
  logic          q_neg_q;
  logic          q_vld_q;

  assign rem = nlo_m_q - qd_q;
  assign ge  = (rem >= bad_pkg::DIV_D);
  assign q_d = {1'b0, qest_q} + QW'(ge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else begin
      q_vld_q <= qd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q     <= q_d;
    q_neg_q <= qd_neg_q;
  end

  // restore the sign and clamp to -90 .. 270
  logic [QW-1:0]        qv;
  logic signed [OW-1:0] mag, angle_d, angle_q;
  logic                 out_vld_q;

  assign qv  = q_q;
  assign mag = OW'(qv);

  always_comb begin
    if (q_neg_q) begin
      angle_d = (qv > bad_pkg::LOW_MAG) ? bad_pkg::OUT_LOW : -mag;
    end else begin
      angle_d = (qv > bad_pkg::HIGH_MAG) ? bad_pkg::OUT_HIGH : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= q_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign valid_o = out_vld_q;
  assign angle_o = angle_q;

endmodule

FILE: src/bearing_angle_degrees.sv
// Pipeline from accepted request to done_o:
// one difference stage, one stage per CORDIC iteration, and six conversion stages
// (half-turn select, rounding, reciprocal multiply, back-multiply, correction, clamp).
// Throughput: one request per cycle; busy is never raised and results cannot be held off.
// Reset clears every valid bit at once; no state other than the pipeline.
module bearing_angle_degrees #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   end_y_i,
  output logic                            done_o,
  output logic signed [bad_pkg::OW-1:0]   angle_deg_o
);

  localparam int XW  = bad_pkg::XW;
  localparam int ZW  = bad_pkg::ZW;
  localparam int LAT = CORDIC_STAGES + bad_pkg::CONV_STAGES + 1;

  logic                 acc;
  logic                 vld_c  [0:CORDIC_STAGES];
  logic signed [XW-1:0] x_c    [0:CORDIC_STAGES];
  logic signed [XW-1:0] y_c    [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_c    [0:CORDIC_STAGES];
  bad_pkg::side_t       side_c [0:CORDIC_STAGES];

  assign busy = 1'b0;
  assign acc  = start && !busy;

  bad_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (acc),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i  (end_x_i),
    .end_y_i  (end_y_i),
    .valid_o  (vld_c[0]),
    .x_o      (x_c[0]),
    .y_o      (y_c[0]),
    .side_o   (side_c[0])
  );

  assign z_c[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    bad_cordic_stage #(
      .IDX(i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld_c[i]),
      .x_i    (x_c[i]),
      .y_i    (y_c[i]),
      .z_i    (z_c[i]),
      .side_i (side_c[i]),
      .valid_o(vld_c[i+1]),
      .x_o    (x_c[i+1]),
      .y_o    (y_c[i+1]),
      .z_o    (z_c[i+1]),
      .side_o (side_c[i+1])
    );
  end

  bad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld_c[CORDIC_STAGES]),
    .z_i    (z_c[CORDIC_STAGES]),
    .side_i (side_c[CORDIC_STAGES]),
    .valid_o(done_o),
    .angle_o(angle_deg_o)
  );

  // every request gives its result after the fixed latency
  a_req_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o)
    else $error("request without result");

  // no result without an earlier accepted request
  a_done_from_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT))
    else $error("result without request");

  // results stay within -90 .. 270 degrees
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_deg_o >= bad_pkg::OUT_LOW) && (angle_deg_o <= bad_pkg::OUT_HIGH))
    else $error("angle out of range");

  // straight up, including the zero vector, is exactly 90 degrees
  a_vertical_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(acc && (start_x_i == end_x_i) && (start_y_i <= end_y_i), LAT)
    |-> angle_deg_o == bad_pkg::LOW_MAG)
    else $error("vertical vector not 90 degrees");

endmodule
